// ===== sv/tlj_pkg.sv =====
package tlj_pkg;

	localparam int FRAC_BITS = 16;
	localparam int CORDIC_N  = 30;
	localparam int CNT_W     = $clog2(CORDIC_N);
	localparam int TRIG_SH   = 30 - FRAC_BITS;

	localparam int LEN_W = 16;
	localparam int ITER_W = 10;
	localparam int ANG_W = 20;
	localparam int POS_W = 18;
	localparam int CFG_W = 20;

	// datapath word, product and quotient widths
	localparam int DW = 22;
	localparam int PW = 2 * DW;
	localparam int QW = PW + 1;
	localparam int DIV_STEPS = PW;
	localparam int DCNT_W = $clog2(DIV_STEPS);

	// CORDIC angle and vector widths (Q30)
	localparam int ZW = 36;
	localparam int XW = 33;

	localparam logic signed [ZW-1:0] PI_Q30      = 36'sd3373259426;
	localparam logic signed [ZW-1:0] HALF_PI_Q30 = 36'sd1686629713;
	localparam logic signed [ZW-1:0] TWO_PI_Q30  = 36'sd6746518852;
	localparam logic signed [XW-1:0] GAIN_Q30    = 33'sd652032874;

	localparam logic signed [ZW-1:0] ATAN_TAB [CORDIC_N] = '{
		36'sd843314857, 36'sd497837829, 36'sd263043837, 36'sd133525159,
		36'sd67021687, 36'sd33543516, 36'sd16775851, 36'sd8388437,
		36'sd4194283, 36'sd2097149, 36'sd1048576, 36'sd524288,
		36'sd262144, 36'sd131072, 36'sd65536, 36'sd32768, 36'sd16384,
		36'sd8192, 36'sd4096, 36'sd2048, 36'sd1024, 36'sd512, 36'sd256,
		36'sd128, 36'sd64, 36'sd32, 36'sd16, 36'sd8, 36'sd4, 36'sd2
	};

	localparam logic signed [QW:0] ANG_MAX = (QW+1)'(524287);
	localparam logic signed [QW:0] ANG_MIN = -(QW+1)'(524288);

	typedef enum logic [2:0] {
		CFG_LINK1  = 3'd0,
		CFG_LINK2  = 3'd1,
		CFG_ITERS  = 3'd2,
		CFG_START1 = 3'd3,
		CFG_START2 = 3'd4
	} cfg_idx_t;

	// micro-operations of one iteration, run in this order
	typedef enum logic [3:0] {
		OP_L1C1, OP_L2C12, OP_L1S1, OP_L2S12, OP_DET1, OP_DET2,
		OP_DX, OP_DY, OP_N1A, OP_N1B, OP_T1, OP_N2A, OP_N2B, OP_T2
	} op_t;

endpackage

// ===== sv/two_link_jacobian_ik.sv =====
// channel | direction | fields                                     | handshake
// in      | request   | target_x, target_y                         | in_valid / in_stall
// out     | result    | joint_angle_one, joint_angle_two, singular | out_valid / out_stall
// cfg     | write     | cfg_index, cfg_data                        | cfg_write
//
// Per iteration: two CORDIC runs, ten multiplies and four divides, one after another;
// a target repeats this up to iteration_count times. The bit-serial divider dominates.
// in_stall is high from the cycle after a request is taken until its result is registered.
// Reset returns the configuration registers to their defaults and clears the sequencer.
// A stalled result holds; the next request may be taken meanwhile.
module two_link_jacobian_ik
	import tlj_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_write,
	input  logic [2:0]               cfg_index,
	input  logic [CFG_W-1:0]         cfg_data,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic signed [POS_W-1:0]  target_x,
	input  logic signed [POS_W-1:0]  target_y,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [ANG_W-1:0]  joint_angle_one,
	output logic signed [ANG_W-1:0]  joint_angle_two,
	output logic                     singular
);

	typedef enum logic [3:0] {
		S_IDLE, S_TLOAD, S_MOD, S_RED, S_FOLD, S_CORD, S_CPOST, S_OP, S_DIV, S_DONE
	} state_t;

	state_t state_q;

	logic [LEN_W-1:0]        cfg_l1_q, cfg_l2_q;
	logic [ITER_W-1:0]       cfg_n_q;
	logic signed [ANG_W-1:0] cfg_t1_q, cfg_t2_q;

	logic [LEN_W-1:0]        l1_q, l2_q;
	logic [ITER_W-1:0]       k_q;
	logic signed [POS_W-1:0] tx_q, ty_q;
	logic signed [ANG_W-1:0] t1_q, t2_q;
	logic                    sel_q, neg_q, phase_q, sing_q;
	op_t                     op_q;

	logic signed [ZW-1:0]    z_q;
	logic signed [XW-1:0]    x_q, y_q;
	logic [CNT_W-1:0]        cnt_q;

	logic signed [DW-1:0]    c1_q, s1_q, c12_q, s12_q;
	logic signed [DW-1:0]    px_q, py_q, j12_q, j22_q, det_q, dx_q, dy_q, acc_q;
	logic signed [PW-1:0]    prod_q, nacc_q, num_q;

	logic [DW-1:0]           rem_q, dvs_q;
	logic [PW-1:0]           quo_q;
	logic                    dneg_q;
	logic [DCNT_W-1:0]       dcnt_q;

	logic                    out_valid_q, sing_out_q;
	logic signed [ANG_W-1:0] a1_out_q, a2_out_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_l1_q <= LEN_W'(19661);
			cfg_l2_q <= LEN_W'(19661);
			cfg_n_q  <= ITER_W'(200);
			cfg_t1_q <= ANG_W'(102944);
			cfg_t2_q <= -ANG_W'(102944);
		end else if (cfg_write) begin
			case (cfg_idx_t'(cfg_index))
				CFG_LINK1:  cfg_l1_q <= cfg_data[LEN_W-1:0];
				CFG_LINK2:  cfg_l2_q <= cfg_data[LEN_W-1:0];
				CFG_ITERS:  cfg_n_q  <= cfg_data[ITER_W-1:0];
				CFG_START1: cfg_t1_q <= $signed(cfg_data[ANG_W-1:0]);
				CFG_START2: cfg_t2_q <= $signed(cfg_data[ANG_W-1:0]);
				default: ;
			endcase
		end
	end

	logic accept;
	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;

	// CORDIC datapath
	logic signed [ANG_W:0]   ang_sum;
	logic signed [ZW-1:0]    z_load, atan_v;
	logic signed [XW-1:0]    xs, ys;
	logic signed [XW-1:0]    x_sh, y_sh;
	logic signed [DW-1:0]    cos_v, sin_v;

	assign ang_sum = sel_q ? (ANG_W+1)'(t1_q) + (ANG_W+1)'(t2_q) : (ANG_W+1)'(t1_q);
	assign z_load  = ZW'(ang_sum) <<< TRIG_SH;
	assign atan_v  = ATAN_TAB[cnt_q];
	assign xs      = x_q >>> cnt_q;
	assign ys      = y_q >>> cnt_q;
	assign x_sh    = x_q >>> TRIG_SH;
	assign y_sh    = y_q >>> TRIG_SH;
	assign cos_v   = neg_q ? -DW'(x_sh) : DW'(x_sh);
	assign sin_v   = neg_q ? -DW'(y_sh) : DW'(y_sh);

	// shared multiplier operands
	logic signed [DW-1:0] ma, mb, l1_s, l2_s, j11;
	logic signed [PW-1:0] prod_fx;
	logic signed [DW-1:0] fm;

	assign l1_s    = $signed(DW'(l1_q));
	assign l2_s    = $signed(DW'(l2_q));
	assign j11     = -py_q;
	assign prod_fx = prod_q >>> FRAC_BITS;
	assign fm      = prod_fx[DW-1:0];

	always_comb begin
		ma = '0;
		mb = '0;
		case (op_q)
			OP_L1C1:  begin ma = l1_s;  mb = c1_q;  end
			OP_L2C12: begin ma = l2_s;  mb = c12_q; end
			OP_L1S1:  begin ma = l1_s;  mb = s1_q;  end
			OP_L2S12: begin ma = l2_s;  mb = s12_q; end
			OP_DET1:  begin ma = j11;   mb = j22_q; end
			OP_DET2:  begin ma = j12_q; mb = px_q;  end
			OP_N1A:   begin ma = j22_q; mb = dx_q;  end
			OP_N1B:   begin ma = j12_q; mb = dy_q;  end
			OP_N2A:   begin ma = j11;   mb = dy_q;  end
			OP_N2B:   begin ma = px_q;  mb = dx_q;  end
			default: ;
		endcase
	end

	// shared divider operands
	logic signed [PW-1:0] dvd;
	logic signed [DW-1:0] dvs;
	logic                 is_div;
	logic [PW-1:0]        dvd_mag;
	logic [DW-1:0]        dvs_mag;

	always_comb begin
		dvd    = num_q;
		dvs    = det_q;
		is_div = 1'b0;
		case (op_q)
			OP_DX: begin
				dvd    = PW'(tx_q) - PW'(px_q);
				dvs    = $signed(DW'(k_q));
				is_div = 1'b1;
			end
			OP_DY: begin
				dvd    = PW'(ty_q) - PW'(py_q);
				dvs    = $signed(DW'(k_q));
				is_div = 1'b1;
			end
			OP_T1, OP_T2: is_div = 1'b1;
			default: ;
		endcase
	end

	assign dvd_mag = dvd[PW-1] ? PW'(-dvd) : PW'(dvd);
	assign dvs_mag = dvs[DW-1] ? DW'(-dvs) : DW'(dvs);

	logic [DW:0]          rem_sh, rem_diff;
	logic                 rem_ge;
	logic signed [QW-1:0] quot;
	logic signed [QW:0]   ang_new;
	logic signed [ANG_W-1:0] ang_sat;
	logic signed [DW-1:0] det_v;

	assign rem_sh   = {rem_q, quo_q[PW-1]};
	assign rem_ge   = rem_sh >= {1'b0, dvs_q};
	assign rem_diff = rem_sh - {1'b0, dvs_q};
	assign quot     = dneg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
	assign ang_new  = (QW+1)'(op_q == OP_T1 ? t1_q : t2_q) + (QW+1)'(quot);
	assign ang_sat  = (ang_new > ANG_MAX) ? ANG_W'(ANG_MAX) :
	                  (ang_new < ANG_MIN) ? ANG_W'(ANG_MIN) : ANG_W'(ang_new);
	assign det_v    = acc_q - fm;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			op_q        <= OP_L1C1;
			phase_q     <= 1'b0;
			sel_q       <= 1'b0;
			neg_q       <= 1'b0;
			sing_q      <= 1'b0;
			k_q         <= '0;
			cnt_q       <= '0;
			dcnt_q      <= '0;
		end else begin
			// the done step reloads the result register itself
			if (out_valid_q && !out_stall && state_q != S_DONE)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						tx_q   <= target_x;
						ty_q   <= target_y;
						l1_q   <= cfg_l1_q;
						l2_q   <= cfg_l2_q;
						k_q    <= cfg_n_q;
						t1_q   <= cfg_t1_q;
						t2_q   <= cfg_t2_q;
						sing_q <= 1'b0;
						sel_q  <= 1'b0;
						state_q <= (cfg_n_q == '0) ? S_DONE : S_TLOAD;
					end
				end
				S_TLOAD: begin
					z_q     <= z_load;
					x_q     <= GAIN_Q30;
					y_q     <= '0;
					neg_q   <= 1'b0;
					state_q <= S_MOD;
				end
				S_MOD: begin
					// remainder keeps the sign of the angle
					if (z_q >= TWO_PI_Q30)
						z_q <= z_q - TWO_PI_Q30;
					else if (z_q <= -TWO_PI_Q30)
						z_q <= z_q + TWO_PI_Q30;
					else
						state_q <= S_RED;
				end
				S_RED: begin
					if (z_q > PI_Q30)
						z_q <= z_q - TWO_PI_Q30;
					else if (z_q < -PI_Q30)
						z_q <= z_q + TWO_PI_Q30;
					state_q <= S_FOLD;
				end
				S_FOLD: begin
					if (z_q > HALF_PI_Q30) begin
						z_q   <= z_q - PI_Q30;
						neg_q <= 1'b1;
					end else if (z_q < -HALF_PI_Q30) begin
						z_q   <= z_q + PI_Q30;
						neg_q <= 1'b1;
					end
					cnt_q   <= '0;
					state_q <= S_CORD;
				end
				S_CORD: begin
					if (!z_q[ZW-1]) begin
						x_q <= x_q - ys;
						y_q <= y_q + xs;
						z_q <= z_q - atan_v;
					end else begin
						x_q <= x_q + ys;
						y_q <= y_q - xs;
						z_q <= z_q + atan_v;
					end
					if (cnt_q == CNT_W'(CORDIC_N - 1))
						state_q <= S_CPOST;
					else
						cnt_q <= cnt_q + 1'b1;
				end
				S_CPOST: begin
					if (!sel_q) begin
						c1_q    <= cos_v;
						s1_q    <= sin_v;
						sel_q   <= 1'b1;
						state_q <= S_TLOAD;
					end else begin
						c12_q   <= cos_v;
						s12_q   <= sin_v;
						op_q    <= OP_L1C1;
						phase_q <= 1'b0;
						state_q <= S_OP;
					end
				end
				S_OP: begin
					if (!phase_q) begin
						if (is_div) begin
							rem_q   <= '0;
							quo_q   <= dvd_mag;
							dvs_q   <= dvs_mag;
							dneg_q  <= dvd[PW-1] ^ dvs[DW-1];
							dcnt_q  <= '0;
							state_q <= S_DIV;
						end else begin
							prod_q  <= PW'(ma * mb);
						end
						phase_q <= 1'b1;
					end else begin
						phase_q <= 1'b0;
						op_q    <= op_t'(op_q + 1'b1);
						case (op_q)
							OP_L1C1:  acc_q <= fm;
							OP_L2C12: begin
								px_q  <= acc_q + fm;
								j22_q <= fm;
							end
							OP_L1S1:  acc_q <= fm;
							OP_L2S12: begin
								py_q  <= acc_q + fm;
								j12_q <= -fm;
							end
							OP_DET1:  acc_q <= fm;
							OP_DET2: begin
								det_q <= det_v;
								if (det_v == '0) begin
									sing_q  <= 1'b1;
									state_q <= S_DONE;
								end
							end
							OP_DX:  dx_q   <= DW'(quot);
							OP_DY:  dy_q   <= DW'(quot);
							OP_N1A: nacc_q <= prod_q;
							OP_N1B: num_q  <= nacc_q - prod_q;
							OP_T1:  t1_q   <= ang_sat;
							OP_N2A: nacc_q <= prod_q;
							OP_N2B: num_q  <= nacc_q - prod_q;
							OP_T2: begin
								t2_q <= ang_sat;
								k_q  <= k_q - 1'b1;
								if (k_q == ITER_W'(1)) begin
									state_q <= S_DONE;
								end else begin
									sel_q   <= 1'b0;
									state_q <= S_TLOAD;
								end
							end
							default: ;
						endcase
					end
				end
				S_DIV: begin
					rem_q  <= rem_ge ? rem_diff[DW-1:0] : rem_sh[DW-1:0];
					quo_q  <= {quo_q[PW-2:0], rem_ge};
					dcnt_q <= dcnt_q + 1'b1;
					if (dcnt_q == DCNT_W'(DIV_STEPS - 1))
						state_q <= S_OP;
				end
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						a1_out_q    <= t1_q;
						a2_out_q    <= t2_q;
						sing_out_q  <= sing_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid       = out_valid_q;
	assign joint_angle_one = a1_out_q;
	assign joint_angle_two = a2_out_q;
	assign singular        = sing_out_q;

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> in_stall)
		else $error("request taken but input not stalled");

	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (dcnt_q < DCNT_W'(DIV_STEPS)))
		else $error("divider ran past its last step");

	a_iter_left: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OP || state_q == S_DIV || state_q == S_CORD) |-> (k_q != '0))
		else $error("iteration work with no iterations left");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_DONE))
		else $error("result raised outside the done step");

endmodule
